[rtl/core/timed_point_table_interpolator_macros.svh]
// assertion macros shared by the interpolator modules
`ifndef TIMED_POINT_TABLE_INTERPOLATOR_MACROS_SVH
`define TIMED_POINT_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define TPTI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpti check failed");

// next-cycle implication
`define TPTI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpti check failed");

`endif

[rtl/core/tpti_pkg.sv]
// shared types and constants of the timed point table interpolator
`default_nettype none
package tpti_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int MAX_POINTS_DEF = 256;

	localparam logic [1:0] REQ_LOAD_TIME  = 2'd0;
	localparam logic [1:0] REQ_LOAD_POINT = 2'd1;
	localparam logic [1:0] REQ_QUERY      = 2'd2;

	localparam logic [1:0] STAT_OK             = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND      = 2'd1;
	localparam logic [1:0] STAT_TIME_MISMATCH  = 2'd2;
	localparam logic [1:0] STAT_NOT_INCREASING = 2'd3;

	localparam logic [1:0] REG_FRAME_COUNT      = 2'd0;
	localparam logic [1:0] REG_POINT_COUNT      = 2'd1;
	localparam logic [1:0] REG_INTERPOLATE_MODE = 2'd2;
	localparam logic [1:0] REG_MATCH_TOLERANCE  = 2'd3;

	localparam logic [4:0]  FRAME_COUNT_RST      = 5'd1;
	localparam logic [8:0]  POINT_COUNT_RST      = 9'd1;
	localparam logic        INTERPOLATE_MODE_RST = 1'b1;
	localparam logic [15:0] MATCH_TOLERANCE_RST  = 16'd26;

	// one quotient bit per step over the 33-bit magnitude
	localparam logic [5:0] DIV_STEPS = 6'd33;

	typedef struct packed {
		logic [4:0]  frame_count;
		logic [8:0]  point_count;
		logic        interpolate_mode;
		logic [15:0] match_tolerance;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DECIDE,
		ST_LK_RD,
		ST_LK_CHK,
		ST_T0_RD,
		ST_T1_RD,
		ST_T_CAP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		FA_IDX,
		FA_P,
		FA_P1
	} faddr_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_HIT,
		RES_DIV
	} res_sel_t;

	typedef struct packed {
		logic       accept;
		logic       scan_clr;
		logic       scan_step;
		logic       lk_start;
		logic       lk_next;
		logic       lk_found;
		logic       t_cap0;
		logic       t_cap1;
		logic       div_step;
		logic       set_res;
		res_sel_t   res_sel;
		logic [1:0] res_status;
		logic       out_load;
		logic       f_re;
		faddr_sel_t f_addr_sel;
		logic       p_re;
	} dp_cmd_t;

	typedef struct packed {
		logic last_frame;
		logic bad_order;
		logic single;
		logic interp;
		logic eq0;
		logic interp_path;
		logic lk_end;
		logic lk_match;
		logic lk_second;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/tpti_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module tpti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/core/tpti_datapath.sv]
// datapath: tables, frame scan, point match, divider and result registers
`default_nettype none
`include "timed_point_table_interpolator_macros.svh"
module tpti_datapath #(
	parameter int MAX_FRAMES = tpti_pkg::MAX_FRAMES_DEF,
	parameter int MAX_POINTS = tpti_pkg::MAX_POINTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tpti_pkg::cfg_t      cfg,
	input  wire tpti_pkg::dp_cmd_t   cmd,
	output tpti_pkg::dp_stat_t       st,
	input  wire logic [1:0]          req_type,
	input  wire logic [3:0]          frame_index,
	input  wire logic [7:0]          point_index,
	input  wire logic signed [47:0]  time_value,
	input  wire logic signed [31:0]  x_coord,
	input  wire logic signed [31:0]  y_coord,
	input  wire logic signed [31:0]  entry_value,
	output logic signed [31:0]       result_value,
	output logic [1:0]               status,
	output logic                     out_valid,
	input  wire logic                out_stall
);
	import tpti_pkg::*;

	localparam int FA  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PA  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NFW = $clog2(MAX_FRAMES + 1);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int PTA = FA + PA;

	logic signed [47:0] t_q;
	logic signed [31:0] x_q, y_q;
	logic [NFW-1:0]     idx_q;
	logic signed [47:0] prev_q;
	logic [FA-1:0]      p_q;
	logic               t_gt0_q, eq0_q, t_lt_last_q;
	logic [PCW-1:0]     pidx_q;
	logic               second_q;
	logic signed [31:0] v0_q, v1_q;
	logic signed [47:0] tp_q;
	logic [48:0]        den_q, num_q, r_q;
	logic [32:0]        a_q, qt_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] pend_val_q;
	logic [1:0]         pend_st_q;
	logic signed [31:0] result_value_q;
	logic [1:0]         status_q;
	logic               out_valid_q;

	logic [NFW-1:0]     nf;
	logic [PCW-1:0]     pc;
	logic               f_we, p_we;
	logic [FA-1:0]      f_raddr, fsel;
	logic [47:0]        f_rdata;
	logic [95:0]        p_rdata;
	logic signed [47:0] cur;
	logic signed [31:0] px, py, pv;
	logic signed [32:0] dx, dy;
	logic signed [33:0] dx34, dy34, tol34, ntol34;
	logic               match;
	logic [48:0]        den_w, num_w;
	logic [32:0]        d_w, mag_w;
	logic [50:0]        s_w, s1_w, s2_w, den1_w, den2_w;

	always_comb begin
		if (cfg.frame_count == '0) begin
			nf = NFW'(1);
		end else if (32'(cfg.frame_count) > 32'(MAX_FRAMES)) begin
			nf = NFW'(MAX_FRAMES);
		end else begin
			nf = NFW'(cfg.frame_count);
		end
		if (32'(cfg.point_count) > 32'(MAX_POINTS)) begin
			pc = PCW'(MAX_POINTS);
		end else begin
			pc = PCW'(cfg.point_count);
		end
	end

	assign f_we = cmd.accept && (req_type == REQ_LOAD_TIME)
		&& (32'(frame_index) < 32'(MAX_FRAMES));
	assign p_we = cmd.accept && (req_type == REQ_LOAD_POINT)
		&& (32'(frame_index) < 32'(MAX_FRAMES)) && (32'(point_index) < 32'(MAX_POINTS));

	always_comb begin
		case (cmd.f_addr_sel)
			FA_IDX: f_raddr = idx_q[FA-1:0];
			FA_P: f_raddr = p_q;
			FA_P1: f_raddr = p_q + FA'(1);
			default: f_raddr = idx_q[FA-1:0];
		endcase
	end

	assign fsel = second_q ? (p_q + FA'(1)) : p_q;

	tpti_ram #(
		.WIDTH(48),
		.DEPTH(2 ** FA)
	) u_frame_ram (
		.clk(clk),
		.we(f_we),
		.waddr(FA'(frame_index)),
		.wdata(time_value),
		.re(cmd.f_re),
		.raddr(f_raddr),
		.rdata(f_rdata)
	);

	tpti_ram #(
		.WIDTH(96),
		.DEPTH(2 ** PTA)
	) u_point_ram (
		.clk(clk),
		.we(p_we),
		.waddr({FA'(frame_index), PA'(point_index)}),
		.wdata({x_coord, y_coord, entry_value}),
		.re(cmd.p_re),
		.raddr({fsel, pidx_q[PA-1:0]}),
		.rdata(p_rdata)
	);

	assign cur = $signed(f_rdata);
	assign px  = $signed(p_rdata[95:64]);
	assign py  = $signed(p_rdata[63:32]);
	assign pv  = $signed(p_rdata[31:0]);

	// strict window on both coordinates
	assign dx     = {px[31], px} - {x_q[31], x_q};
	assign dy     = {py[31], py} - {y_q[31], y_q};
	assign dx34   = {dx[32], dx};
	assign dy34   = {dy[32], dy};
	assign tol34  = $signed({18'b0, cfg.match_tolerance});
	assign ntol34 = -tol34;
	assign match  = (dx34 < tol34) && (dx34 > ntol34) && (dy34 < tol34) && (dy34 > ntol34);

	assign den_w = 49'({cur[47], cur} - {tp_q[47], tp_q});
	assign num_w = 49'({t_q[47], t_q} - {tp_q[47], tp_q});
	assign d_w   = {v1_q[31], v1_q} - {v0_q[31], v0_q};
	assign mag_w = d_w[32] ? (33'd0 - d_w) : d_w;

	// one quotient step: remainder stays below den, at most two subtractions
	assign den1_w = {2'b00, den_q};
	assign den2_w = {1'b0, den_q, 1'b0};
	assign s_w    = {1'b0, r_q, 1'b0} + (a_q[32] ? {2'b00, num_q} : 51'd0);
	assign s1_w   = s_w - den1_w;
	assign s2_w   = s_w - den2_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= time_value;
			x_q <= x_coord;
			y_q <= y_coord;
		end
		if (cmd.scan_clr) begin
			idx_q <= '0;
			p_q   <= '0;
		end
		if (cmd.scan_step) begin
			if (idx_q == '0) begin
				t_gt0_q <= t_q > cur;
				eq0_q   <= t_q == cur;
			end
			if (cur <= t_q) begin
				p_q <= idx_q[FA-1:0];
			end
			t_lt_last_q <= t_q < cur;
			prev_q      <= cur;
			idx_q       <= idx_q + NFW'(1);
		end
		if (cmd.lk_start) begin
			pidx_q   <= '0;
			second_q <= 1'b0;
		end
		if (cmd.lk_next) begin
			pidx_q <= pidx_q + PCW'(1);
		end
		if (cmd.lk_found) begin
			if (!second_q) begin
				v0_q     <= pv;
				second_q <= 1'b1;
				pidx_q   <= '0;
			end else begin
				v1_q <= pv;
			end
		end
		if (cmd.t_cap0) begin
			tp_q <= cur;
		end
		if (cmd.t_cap1) begin
			den_q <= den_w;
			num_q <= num_w;
			a_q   <= mag_w;
			neg_q <= d_w[32];
			r_q   <= '0;
			qt_q  <= '0;
			cnt_q <= DIV_STEPS;
		end
		if (cmd.div_step) begin
			a_q   <= {a_q[31:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
			if (s_w >= den2_w) begin
				r_q  <= s2_w[48:0];
				qt_q <= {qt_q[31:0], 1'b0} + 33'd2;
			end else if (s_w >= den1_w) begin
				r_q  <= s1_w[48:0];
				qt_q <= {qt_q[31:0], 1'b1};
			end else begin
				r_q  <= s_w[48:0];
				qt_q <= {qt_q[31:0], 1'b0};
			end
		end
		if (cmd.set_res) begin
			pend_st_q <= cmd.res_status;
			case (cmd.res_sel)
				RES_ZERO: pend_val_q <= '0;
				RES_HIT: pend_val_q <= pv;
				RES_DIV: pend_val_q <= neg_q ? (v0_q - $signed(qt_q[31:0]))
					: (v0_q + $signed(qt_q[31:0]));
				default: pend_val_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			result_value_q <= pend_val_q;
			status_q       <= pend_st_q;
		end
	end

	always_comb begin
		st.last_frame  = idx_q == (nf - NFW'(1));
		st.bad_order   = (idx_q != '0) && (prev_q >= cur);
		st.single      = nf == NFW'(1);
		st.interp      = cfg.interpolate_mode;
		st.eq0         = eq0_q;
		st.interp_path = cfg.interpolate_mode && (nf != NFW'(1)) && t_gt0_q && t_lt_last_q;
		st.lk_end      = pidx_q >= pc;
		st.lk_match    = match;
		st.lk_second   = second_q;
		st.div_done    = cnt_q == 6'd0;
		st.out_free    = !out_valid_q || !out_stall;
	end

	assign result_value = result_value_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;

	`TPTI_ASSERT_NOW(a_found_is_match, cmd.lk_found, match)
	`TPTI_ASSERT_NOW(a_scan_in_range, cmd.scan_step, idx_q < nf)
	`TPTI_ASSERT_NOW(a_load_needs_room, cmd.out_load, !out_valid_q || !out_stall)

endmodule
`default_nettype wire

[rtl/core/tpti_ctrl.sv]
// controller state machine sequencing scan, lookups and division
`default_nettype none
`include "timed_point_table_interpolator_macros.svh"
module tpti_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         req_type,
	output logic                    in_stall,
	input  wire tpti_pkg::dp_stat_t st,
	output tpti_pkg::dp_cmd_t       cmd
);
	import tpti_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_QUERY) ? ST_SCAN_RD : ST_OUT;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (st.bad_order) begin
					state_d = ST_OUT;
				end else if (st.last_frame) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_DECIDE: begin
				if (st.single && !st.interp && !st.eq0) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_LK_RD;
				end
			end
			ST_LK_RD: state_d = st.lk_end ? ST_OUT : ST_LK_CHK;
			ST_LK_CHK: begin
				if (!st.lk_match) begin
					state_d = ST_LK_RD;
				end else if (st.interp_path && !st.lk_second) begin
					state_d = ST_LK_RD;
				end else if (st.interp_path) begin
					state_d = ST_T0_RD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_T0_RD: state_d = ST_T1_RD;
			ST_T1_RD: state_d = ST_T_CAP;
			ST_T_CAP: state_d = ST_DIV;
			ST_DIV: state_d = st.div_done ? ST_OUT : ST_DIV;
			ST_OUT: state_d = st.out_free ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_QUERY) begin
						cmd.scan_clr = 1'b1;
					end else begin
						cmd.set_res    = 1'b1;
						cmd.res_sel    = RES_ZERO;
						cmd.res_status = STAT_OK;
					end
				end
			end
			ST_SCAN_RD: begin
				cmd.f_re       = 1'b1;
				cmd.f_addr_sel = FA_IDX;
			end
			ST_SCAN_CHK: begin
				cmd.scan_step = 1'b1;
				if (st.bad_order) begin
					cmd.set_res    = 1'b1;
					cmd.res_sel    = RES_ZERO;
					cmd.res_status = STAT_NOT_INCREASING;
				end
			end
			ST_DECIDE: begin
				if (st.single && !st.interp && !st.eq0) begin
					cmd.set_res    = 1'b1;
					cmd.res_sel    = RES_ZERO;
					cmd.res_status = STAT_TIME_MISMATCH;
				end else begin
					cmd.lk_start = 1'b1;
				end
			end
			ST_LK_RD: begin
				if (st.lk_end) begin
					cmd.set_res    = 1'b1;
					cmd.res_sel    = RES_ZERO;
					cmd.res_status = STAT_NOT_FOUND;
				end else begin
					cmd.p_re = 1'b1;
				end
			end
			ST_LK_CHK: begin
				if (!st.lk_match) begin
					cmd.lk_next = 1'b1;
				end else begin
					cmd.lk_found = 1'b1;
					if (!st.interp_path) begin
						cmd.set_res    = 1'b1;
						cmd.res_sel    = RES_HIT;
						cmd.res_status = STAT_OK;
					end
				end
			end
			ST_T0_RD: begin
				cmd.f_re       = 1'b1;
				cmd.f_addr_sel = FA_P;
			end
			ST_T1_RD: begin
				cmd.f_re       = 1'b1;
				cmd.f_addr_sel = FA_P1;
				cmd.t_cap0     = 1'b1;
			end
			ST_T_CAP: cmd.t_cap1 = 1'b1;
			ST_DIV: begin
				if (st.div_done) begin
					cmd.set_res    = 1'b1;
					cmd.res_sel    = RES_DIV;
					cmd.res_status = STAT_OK;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_OUT: cmd.out_load = st.out_free;
			default: cmd = '0;
		endcase
	end

	`TPTI_ASSERT_NEXT(a_div_starts_busy, state_q == ST_T_CAP, state_q == ST_DIV && !st.div_done)
	`TPTI_ASSERT_NEXT(a_second_lookup,
		state_q == ST_LK_CHK && st.lk_match && st.interp_path && !st.lk_second,
		state_q == ST_LK_RD && st.lk_second)
	`TPTI_ASSERT_NOW(a_no_reads_at_out, state_q == ST_OUT, !cmd.f_re && !cmd.p_re)

endmodule
`default_nettype wire

[rtl/core/timed_point_table_interpolator.sv]
// top level: register port, controller and datapath of the point table interpolator
//
//   channel  signals                                   role
//   in       in_valid/in_stall + request fields        load or query transaction
//   out      out_valid/out_stall + result_value,status  one result per transaction
//   cfg      apb psel/penable/pwrite/paddr/pwdata       four control registers
//
// loads go straight to the output state; a query reads each frame time in turn,
// then scans the point table, twice when it interpolates, then runs the bit-serial divider
// the point scan runs entry by entry through the single read port of the point memory
// a new transaction is taken while a finished result still waits on out_stall
// no clearing pass after reset; tables are undefined until loaded
`default_nettype none
module timed_point_table_interpolator #(
	parameter int MAX_FRAMES = tpti_pkg::MAX_FRAMES_DEF,
	parameter int MAX_POINTS = tpti_pkg::MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [3:0]         frame_index,
	input  wire logic [7:0]         point_index,
	input  wire logic signed [47:0] time_value,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	input  wire logic signed [31:0] entry_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_value,
	output logic [1:0]              status
);
	import tpti_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t st;
	logic     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count      <= FRAME_COUNT_RST;
			cfg_q.point_count      <= POINT_COUNT_RST;
			cfg_q.interpolate_mode <= INTERPOLATE_MODE_RST;
			cfg_q.match_tolerance  <= MATCH_TOLERANCE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FRAME_COUNT: cfg_q.frame_count <= pwdata[4:0];
				REG_POINT_COUNT: cfg_q.point_count <= pwdata[8:0];
				REG_INTERPOLATE_MODE: cfg_q.interpolate_mode <= pwdata[0];
				REG_MATCH_TOLERANCE: cfg_q.match_tolerance <= pwdata[15:0];
				default: cfg_q.frame_count <= cfg_q.frame_count;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_COUNT: prdata = {27'b0, cfg_q.frame_count};
			REG_POINT_COUNT: prdata = {23'b0, cfg_q.point_count};
			REG_INTERPOLATE_MODE: prdata = {31'b0, cfg_q.interpolate_mode};
			REG_MATCH_TOLERANCE: prdata = {16'b0, cfg_q.match_tolerance};
			default: prdata = '0;
		endcase
	end

	tpti_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.in_stall(in_stall),
		.st(st),
		.cmd(cmd)
	);

	tpti_datapath #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_POINTS(MAX_POINTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.st(st),
		.req_type(req_type),
		.frame_index(frame_index),
		.point_index(point_index),
		.time_value(time_value),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.entry_value(entry_value),
		.result_value(result_value),
		.status(status),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

endmodule
`default_nettype wire
